// ===== sv/sssp_pkg.sv =====
`timescale 1ns / 1ps

package sssp_pkg;

  // Fixed field widths
  localparam int VTX_BITS  = 6;
  localparam int W_BITS    = 16;
  localparam int DOUT_BITS = 32;
  localparam int CNT_BITS  = 7;

  // Configuration port
  localparam int ADDR_BITS = 3;
  localparam int DATA_BITS = 32;
  localparam logic [CNT_BITS-1:0] VCOUNT_RESET = 7'd2;

  // Register index codes (paddr bit 2)
  localparam logic REG_VCOUNT = 1'b0;
  localparam logic REG_SOURCE = 1'b1;

  typedef logic [VTX_BITS-1:0]         vtx_t;
  typedef logic [CNT_BITS-1:0]         vcount_t;
  typedef logic signed [W_BITS-1:0]    weight_t;
  typedef logic signed [DOUT_BITS-1:0] dout_t;

  // Controller to datapath commands
  typedef struct packed {
    logic in_ready;
    logic init;
    logic pass_start;
    logic round_inc;
    logic edge_rd;
    logic dist_rd;
    logic relax_wr;
    logic out_rd;
    logic out_load;
    logic neg_load;
    logic out_valid;
    logic clear_total;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_valid;
    logic in_last;
    logic edge_left;
    logic improve;
    logic changed;
    logic round_last;
    logic out_ready;
    logic out_last;
  } stat_t;

  // Result register
  typedef struct packed {
    vtx_t  vertex_index;
    logic  reachable;
    dout_t distance;
    vtx_t  predecessor;
    logic  has_predecessor;
    logic  negative_cycle;
    logic  last_result;
  } res_t;

endpackage

// ===== sv/sssp_edge_if.sv =====
`timescale 1ns / 1ps

interface sssp_edge_if;
  logic                   valid;
  logic                   ready;
  sssp_pkg::vtx_t         edge_from;
  sssp_pkg::vtx_t         edge_to;
  sssp_pkg::weight_t      edge_weight;
  logic                   last_edge;

  modport source (output valid, edge_from, edge_to, edge_weight, last_edge, input ready);
  modport sink   (input valid, edge_from, edge_to, edge_weight, last_edge, output ready);
endinterface

// ===== sv/sssp_res_if.sv =====
`timescale 1ns / 1ps

interface sssp_res_if;
  logic              valid;
  logic              ready;
  sssp_pkg::vtx_t    vertex_index;
  logic              reachable;
  sssp_pkg::dout_t   distance;
  sssp_pkg::vtx_t    predecessor;
  logic              has_predecessor;
  logic              negative_cycle;
  logic              last_result;

  modport source (output valid, vertex_index, reachable, distance, predecessor,
                  has_predecessor, negative_cycle, last_result, input ready);
  modport sink   (input valid, vertex_index, reachable, distance, predecessor,
                  has_predecessor, negative_cycle, last_result, output ready);
endinterface

// ===== sv/sssp_cfg.sv =====
`timescale 1ns / 1ps

module sssp_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sssp_pkg::ADDR_BITS-1:0] paddr,
  input  logic [sssp_pkg::DATA_BITS-1:0] pwdata,
  output logic [sssp_pkg::DATA_BITS-1:0] prdata,
  output logic                          pready,
  output sssp_pkg::vcount_t             vertex_count,
  output sssp_pkg::vtx_t                source_vertex
);
  import sssp_pkg::*;

  vcount_t vcount_r;
  vtx_t    source_r;
  logic    reg_idx;
  logic    wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel & penable & pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= VCOUNT_RESET;
      source_r <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_VCOUNT: vcount_r <= pwdata[CNT_BITS-1:0];
        REG_SOURCE: source_r <= pwdata[VTX_BITS-1:0];
        default:    vcount_r <= vcount_r;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_idx)
      REG_VCOUNT: prdata = DATA_BITS'(vcount_r);
      REG_SOURCE: prdata = DATA_BITS'(source_r);
      default:    prdata = '0;
    endcase
  end

  assign vertex_count  = vcount_r;
  assign source_vertex = source_r;

endmodule

// ===== sv/sssp_ctrl.sv =====
`timescale 1ns / 1ps

module sssp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  sssp_pkg::stat_t stat,
  output sssp_pkg::cmd_t  cmd
);
  import sssp_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_INIT  = 8'b0000_0010,
    S_EDGE  = 8'b0000_0100,
    S_DIST  = 8'b0000_1000,
    S_RELAX = 8'b0001_0000,
    S_ORD   = 8'b0010_0000,
    S_OLOAD = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   check_r, check_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      check_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      check_r <= check_nxt;
    end
  end

  // check_r: 0 during relaxation rounds, 1 during the negative-cycle pass
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    check_nxt = check_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (stat.in_valid && stat.in_last) state_nxt = S_INIT;
      end
      S_INIT: begin
        cmd.init       = 1'b1;
        cmd.pass_start = 1'b1;
        check_nxt      = 1'b0;
        state_nxt      = S_EDGE;
      end
      S_EDGE: begin
        if (stat.edge_left) begin
          cmd.edge_rd = 1'b1;
          state_nxt   = S_DIST;
        end else if (check_r) begin
          state_nxt = S_ORD;
        end else begin
          // end of a round: another round, or the check pass
          cmd.pass_start = 1'b1;
          if (!stat.changed || stat.round_last) check_nxt = 1'b1;
          else cmd.round_inc = 1'b1;
        end
      end
      S_DIST: begin
        cmd.dist_rd = 1'b1;
        state_nxt   = S_RELAX;
      end
      S_RELAX: begin
        if (check_r) begin
          if (stat.improve) begin
            cmd.neg_load = 1'b1;
            state_nxt    = S_EMIT;
          end else begin
            state_nxt = S_EDGE;
          end
        end else begin
          cmd.relax_wr = 1'b1;
          state_nxt    = S_EDGE;
        end
      end
      S_ORD: begin
        cmd.out_rd = 1'b1;
        state_nxt  = S_OLOAD;
      end
      S_OLOAD: begin
        cmd.out_load = 1'b1;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        cmd.out_valid = 1'b1;
        if (stat.out_ready) begin
          if (stat.out_last) begin
            cmd.clear_total = 1'b1;
            state_nxt       = S_IDLE;
          end else begin
            state_nxt = S_ORD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== sv/sssp_dpath.sv =====
`timescale 1ns / 1ps

module sssp_dpath #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256,
  parameter int DIST_BITS    = 31
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sssp_pkg::cmd_t    cmd,
  output sssp_pkg::stat_t   stat,
  input  sssp_pkg::vcount_t vertex_count,
  input  sssp_pkg::vtx_t    source_vertex,
  sssp_edge_if.sink         in_edge,
  sssp_res_if.source        out_res
);
  import sssp_pkg::*;

  localparam int VB = $clog2(MAX_VERTICES);
  localparam int EB = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int TB = $clog2(MAX_EDGES + 1);
  localparam int EW = 2 * VB + W_BITS;
  localparam int XB = (DIST_BITS > DOUT_BITS) ? DIST_BITS : DOUT_BITS + 1;
  localparam logic signed [XB-1:0] SAT_HI = XB'($signed(32'h7FFF_FFFF));
  localparam logic signed [XB-1:0] SAT_LO = XB'($signed(32'h8000_0000));

  // Memories
  logic [EW-1:0]                edge_mem_r [MAX_EDGES];
  logic signed [DIST_BITS-1:0]  dist_mem_r [MAX_VERTICES];
  logic [VB-1:0]                pred_mem_r [MAX_VERTICES];

  // Control registers
  logic [TB-1:0]           total_r;
  logic [TB-1:0]           eidx_r;
  logic [VB-1:0]           round_r;
  logic [VB-1:0]           oidx_r;
  logic                    changed_r;
  logic [MAX_VERTICES-1:0] dvalid_r;
  logic [MAX_VERTICES-1:0] pvalid_r;

  // Read data and result registers
  logic [EW-1:0]               edge_rd_r;
  logic signed [DIST_BITS-1:0] da_r;
  logic signed [DIST_BITS-1:0] db_r;
  logic [VB-1:0]               pa_r;
  res_t                        out_r;
  res_t                        out_nxt;

  vcount_t                     nv;
  vcount_t                     nv_m1;
  logic                        in_fire;
  logic                        fits;
  logic                        src_ok;
  logic [VB-1:0]               src_idx;
  logic [VB-1:0]               e_from;
  logic [VB-1:0]               e_to;
  weight_t                     e_w;
  logic signed [DIST_BITS-1:0] sum;
  logic                        e_ok;
  logic                        improve;
  logic                        mem_we;
  logic [VB-1:0]               mem_wa;
  logic signed [DIST_BITS-1:0] mem_wd;
  logic [VB-1:0]               rd_addr;
  logic signed [XB-1:0]        dx;
  dout_t                       dist_sat;

  // Vertex count clamped to 2..MAX_VERTICES
  always_comb begin
    if (vertex_count < CNT_BITS'(2))                 nv = CNT_BITS'(2);
    else if (vertex_count > CNT_BITS'(MAX_VERTICES)) nv = CNT_BITS'(MAX_VERTICES);
    else                                             nv = vertex_count;
  end
  assign nv_m1   = nv - CNT_BITS'(1);
  assign src_ok  = CNT_BITS'(source_vertex) < nv;
  assign src_idx = source_vertex[VB-1:0];

  // Edge load: drop out-of-range vertices and overflow
  assign in_fire = in_edge.valid & cmd.in_ready;
  assign fits    = (CNT_BITS'(in_edge.edge_from) < nv) && (CNT_BITS'(in_edge.edge_to) < nv)
                   && (total_r < TB'(MAX_EDGES));

  always_ff @(posedge clk) begin
    if (in_fire && fits)
      edge_mem_r[total_r[EB-1:0]] <= {in_edge.edge_from[VB-1:0], in_edge.edge_to[VB-1:0],
                                      in_edge.edge_weight};
    if (cmd.edge_rd) edge_rd_r <= edge_mem_r[eidx_r[EB-1:0]];
  end

  assign e_from = edge_rd_r[EW-1 -: VB];
  assign e_to   = edge_rd_r[EW-1-VB -: VB];
  assign e_w    = edge_rd_r[W_BITS-1:0];

  // Relaxation test
  assign sum  = da_r + DIST_BITS'(e_w);
  assign e_ok = (CNT_BITS'(e_from) < nv) && (CNT_BITS'(e_to) < nv);
  always_comb begin
    improve = 1'b0;
    if (e_ok && dvalid_r[e_from]) improve = !dvalid_r[e_to] || (sum < db_r);
  end

  // Distance / predecessor write port
  assign mem_we = (cmd.init & src_ok) | (cmd.relax_wr & improve);
  assign mem_wa = cmd.init ? src_idx : e_to;
  assign mem_wd = cmd.init ? '0 : sum;
  assign rd_addr = cmd.out_rd ? oidx_r : e_from;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      dist_mem_r[mem_wa] <= mem_wd;
      pred_mem_r[mem_wa] <= e_from;
    end
    if (cmd.dist_rd || cmd.out_rd) begin
      da_r <= dist_mem_r[rd_addr];
      pa_r <= pred_mem_r[rd_addr];
    end
    if (cmd.dist_rd) db_r <= dist_mem_r[e_to];
  end

  // Counters, flags and valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r   <= '0;
      eidx_r    <= '0;
      round_r   <= '0;
      oidx_r    <= '0;
      changed_r <= 1'b0;
      dvalid_r  <= '0;
      pvalid_r  <= '0;
    end else begin
      if (cmd.clear_total)     total_r <= '0;
      else if (in_fire && fits) total_r <= total_r + TB'(1);

      if (cmd.pass_start)   eidx_r <= '0;
      else if (cmd.edge_rd) eidx_r <= eidx_r + TB'(1);

      if (cmd.pass_start)                 changed_r <= 1'b0;
      else if (cmd.relax_wr && improve)   changed_r <= 1'b1;

      if (cmd.init)           round_r <= VB'(1);
      else if (cmd.round_inc) round_r <= round_r + VB'(1);

      if (cmd.init)          oidx_r <= '0;
      else if (cmd.out_load) oidx_r <= oidx_r + VB'(1);

      // only the source starts reachable
      if (cmd.init) begin
        dvalid_r <= src_ok ? (MAX_VERTICES'(1) << src_idx) : '0;
        pvalid_r <= '0;
      end else if (cmd.relax_wr && improve) begin
        dvalid_r[e_to] <= 1'b1;
        pvalid_r[e_to] <= 1'b1;
      end
    end
  end

  // Saturate to signed 32 bits
  always_comb begin
    dx = XB'(da_r);
    if (dx > SAT_HI)      dist_sat = SAT_HI[DOUT_BITS-1:0];
    else if (dx < SAT_LO) dist_sat = SAT_LO[DOUT_BITS-1:0];
    else                  dist_sat = dx[DOUT_BITS-1:0];
  end

  // Next result beat: vertex result, or the lone negative-cycle beat
  always_comb begin
    out_nxt = '0;
    if (cmd.out_load) begin
      out_nxt.vertex_index    = VTX_BITS'(oidx_r);
      out_nxt.reachable       = dvalid_r[oidx_r];
      out_nxt.distance        = dvalid_r[oidx_r] ? dist_sat : '0;
      out_nxt.predecessor     = pvalid_r[oidx_r] ? VTX_BITS'(pa_r) : '0;
      out_nxt.has_predecessor = pvalid_r[oidx_r];
      out_nxt.last_result     = (CNT_BITS'(oidx_r) == nv_m1);
    end else begin
      out_nxt.negative_cycle  = 1'b1;
      out_nxt.last_result     = 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load || cmd.neg_load) out_r <= out_nxt;
  end

  // Channels
  assign in_edge.ready           = cmd.in_ready;
  assign out_res.valid           = cmd.out_valid;
  assign out_res.vertex_index    = out_r.vertex_index;
  assign out_res.reachable       = out_r.reachable;
  assign out_res.distance        = out_r.distance;
  assign out_res.predecessor     = out_r.predecessor;
  assign out_res.has_predecessor = out_r.has_predecessor;
  assign out_res.negative_cycle  = out_r.negative_cycle;
  assign out_res.last_result     = out_r.last_result;

  // Status
  assign stat.in_valid   = in_edge.valid;
  assign stat.in_last    = in_edge.last_edge;
  assign stat.edge_left  = eidx_r < total_r;
  assign stat.improve    = improve;
  assign stat.changed    = changed_r;
  assign stat.round_last = CNT_BITS'(round_r) == nv_m1;
  assign stat.out_ready  = out_res.ready;
  assign stat.out_last   = out_r.last_result;

endmodule

// ===== sv/single_source_shortest_path_core.sv =====
`timescale 1ns / 1ps
// Channel   Port group            Direction  Beat carries
// edges     in_edge (sink)        in         edge_from, edge_to, edge_weight, last_edge
// results   out_res (source)      out        vertex, reachable, distance, predecessor, flags
// config    psel..pready (APB)    in/out     vertex_count @ 0x0, source_vertex @ 0x4
//
// Edges load one beat per cycle while idle. The edge with last_edge set starts the run;
// input is held off until the last result beat is taken. A run makes R relaxation rounds
// (R <= V-1) and a check pass over the E stored edges, then emits the results; each edge
// passes through edge-store read, distance-memory read and update.
// rst_n is synchronous, active low; it empties the edge store and restores the registers.

module single_source_shortest_path_core #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  sssp_edge_if.sink                      in_edge,
  sssp_res_if.source                     out_res,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sssp_pkg::ADDR_BITS-1:0] paddr,
  input  logic [sssp_pkg::DATA_BITS-1:0] pwdata,
  output logic [sssp_pkg::DATA_BITS-1:0] prdata,
  output logic                           pready
);
  import sssp_pkg::*;

  // Wide enough that no path sum over all relaxations can wrap
  localparam int DIST_BITS = W_BITS + $clog2(MAX_VERTICES) + $clog2(MAX_EDGES) + 1;

  cmd_t    cmd;
  stat_t   stat;
  vcount_t vertex_count;
  vtx_t    source_vertex;

  sssp_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .vertex_count (vertex_count),
    .source_vertex(source_vertex)
  );

  sssp_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .stat (stat),
    .cmd  (cmd)
  );

  sssp_dpath #(
    .MAX_VERTICES(MAX_VERTICES),
    .MAX_EDGES   (MAX_EDGES),
    .DIST_BITS   (DIST_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .vertex_count (vertex_count),
    .source_vertex(source_vertex),
    .in_edge      (in_edge),
    .out_res      (out_res)
  );

endmodule

// ===== sv/sssp_chk.sv =====
`timescale 1ns / 1ps

module sssp_chk (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 out_reachable,
  input logic                 out_negative_cycle,
  input logic                 out_last_result,
  input sssp_pkg::dout_t      out_distance,
  input sssp_pkg::vtx_t       out_vertex_index
);

  // No result beat right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Edge loading and result delivery never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("input ready while result pending");

  // Stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_distance)
      && $stable(out_vertex_index))
    else $error("stalled result changed");

  // Final beat of a run frees the input side
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_result |=> in_ready)
    else $error("input not ready after final result");

  // Negative-cycle result is the last beat of its run and is marked unreachable
  a_neg_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_negative_cycle |-> out_last_result && !out_reachable)
    else $error("malformed negative-cycle result");

endmodule

bind single_source_shortest_path_core sssp_chk u_sssp_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_edge.ready),
  .out_valid         (out_res.valid),
  .out_ready         (out_res.ready),
  .out_reachable     (out_res.reachable),
  .out_negative_cycle(out_res.negative_cycle),
  .out_last_result   (out_res.last_result),
  .out_distance      (out_res.distance),
  .out_vertex_index  (out_res.vertex_index)
);

// ===== verif/tb_single_source_shortest_path_core.sv =====
`timescale 1ns / 1ps

module tb_single_source_shortest_path_core;
  import sssp_pkg::*;

  localparam int MAX_V        = 64;
  localparam int EDGE_CAP     = 256;
  localparam int RANDOM_EDGES = 70;
  localparam int SETTLE       = 8;
  localparam int TAIL_CYCLES  = 20;
  localparam int LIMIT_NS     = 2_000_000;

  localparam logic [ADDR_BITS-1:0] VCOUNT_ADDR = {REG_VCOUNT, 2'b00};
  localparam logic [ADDR_BITS-1:0] SOURCE_ADDR = {REG_SOURCE, 2'b00};

  // Stored edge as the path solver sees it
  typedef struct {
    int     tail;
    int     head;
    longint weight;
  } arc_t;

  // One row of the directed plan; known results are typed in where obvious
  typedef struct {
    bit      reconfig;
    vcount_t vcount;
    vtx_t    source;
    vtx_t    tail;
    vtx_t    head;
    weight_t weight;
    bit      last;
    int      known_first;
    int      known_count;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [DATA_BITS-1:0] pwdata;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  sssp_edge_if in_edge ();
  sssp_res_if  out_res ();

  single_source_shortest_path_core #(
    .MAX_VERTICES(MAX_V),
    .MAX_EDGES   (EDGE_CAP)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_edge(in_edge),
    .out_res(out_res),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #1 clk = ~clk;

  // Solver state and its copy of the registers
  vcount_t   vc_reg = VCOUNT_RESET;
  vtx_t      src_reg = '0;
  arc_t      arcs[$];
  longint    best_dist[MAX_V];
  bit        reached[MAX_V];
  int        hop_from[MAX_V];
  bit        has_hop[MAX_V];

  res_t      due_results[$];
  int        known_tag[$];
  plan_row_t plan[$];
  res_t      known_res[$];

  int        err_count;
  int        graphs;
  int        neg_graphs;
  int        edge_beats;
  int        result_beats;
  int        cfg_writes;
  int        stall_left;
  bit        calm;

  function automatic int sat_count(int vc);
    if (vc < 2) return 2;
    if (vc > MAX_V) return MAX_V;
    return vc;
  endfunction

  function automatic res_t mk_res(int vi, bit reach, longint d, int p, bit hp, bit neg,
                                  bit lst);
    res_t r;
    if (d > 64'sd2147483647) d = 64'sd2147483647;
    if (d < -64'sd2147483648) d = -64'sd2147483648;
    r.vertex_index    = vtx_t'(vi);
    r.reachable       = reach;
    r.distance        = dout_t'(d);
    r.predecessor     = vtx_t'(p);
    r.has_predecessor = hp;
    r.negative_cycle  = neg;
    r.last_result     = lst;
    return r;
  endfunction

  // One sweep over the stored edges; without apply it only looks for an improvement
  function automatic bit sweep_arcs(int nv, bit apply);
    bit any;
    any = 1'b0;
    foreach (arcs[j]) begin
      int     u;
      int     v;
      longint sum;
      u = arcs[j].tail;
      v = arcs[j].head;
      if (u >= nv || v >= nv || !reached[u]) continue;
      sum = best_dist[u] + arcs[j].weight;
      if (!reached[v] || sum < best_dist[v]) begin
        if (!apply) return 1'b1;
        any          = 1'b1;
        best_dist[v] = sum;
        reached[v]   = 1'b1;
        hop_from[v]  = u;
        has_hop[v]   = 1'b1;
      end
    end
    return any;
  endfunction

  // Store an accepted edge; the last one solves the graph and queues its results
  function automatic void absorb_edge(vtx_t f, vtx_t t, weight_t w, bit last, int tag);
    int   nv;
    arc_t a;
    res_t found[$];
    nv = sat_count(vc_reg);
    if (f < nv && t < nv && arcs.size() < EDGE_CAP) begin
      a.tail   = f;
      a.head   = t;
      a.weight = w;
      arcs.insert(arcs.size(), a);
    end
    if (!last) return;

    for (int i = 0; i < MAX_V; i++) begin
      best_dist[i] = 0;
      reached[i]   = (i == src_reg);
      hop_from[i]  = 0;
      has_hop[i]   = 1'b0;
    end
    for (int r = 1; r < nv; r++)
      if (!sweep_arcs(nv, 1'b1)) break;

    if (sweep_arcs(nv, 1'b0)) begin
      found.insert(found.size(), mk_res(0, 1'b0, 0, 0, 1'b0, 1'b1, 1'b1));
      neg_graphs++;
    end else begin
      for (int i = 0; i < nv; i++)
        found.insert(found.size(), mk_res(i, reached[i], reached[i] ? best_dist[i] : 0,
                                          hop_from[i], has_hop[i], 1'b0, i == nv - 1));
    end

    if (tag >= 0) begin
      for (int k = 0; k < plan[tag].known_count; k++)
        due_results.insert(due_results.size(), known_res[plan[tag].known_first + k]);
    end else begin
      foreach (found[k]) due_results.insert(due_results.size(), found[k]);
    end
    arcs.delete();
    graphs++;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Mostly short gaps, a few long ones, none during calm stretches
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic vtx_t pick_vertex(int nv);
    if ($urandom_range(0, 9) == 0) return vtx_t'($urandom_range(0, 63));
    return vtx_t'($urandom_range(0, nv - 1));
  endfunction

  function automatic weight_t pick_weight();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return weight_t'($urandom_range(0, 50));
    if (r < 75) return weight_t'(-int'($urandom_range(1, 30)));
    if (r < 90) return weight_t'($urandom);
    return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
  endfunction

  function automatic void add_known(int vi, bit reach, int d, int p, bit hp, bit neg, bit lst);
    known_res.insert(known_res.size(), mk_res(vi, reach, d, p, hp, neg, lst));
  endfunction

  function automatic void add_row(bit reconfig, int vc, int src, int f, int t, int w, bit last,
                                  int nknown);
    plan_row_t row;
    row.reconfig    = reconfig;
    row.vcount      = vcount_t'(vc);
    row.source      = vtx_t'(src);
    row.tail        = vtx_t'(f);
    row.head        = vtx_t'(t);
    row.weight      = weight_t'(w);
    row.last        = last;
    row.known_first = known_res.size() - nknown;
    row.known_count = nknown;
    plan.insert(plan.size(), row);
  endfunction

  // Edge beats into the solver
  always @(posedge clk) begin : edge_monitor
    int tag;
    if (rst_n && in_edge.valid && in_edge.ready) begin
      tag = (known_tag.size() != 0) ? known_tag.pop_front() : -1;
      edge_beats++;
      absorb_edge(in_edge.edge_from, in_edge.edge_to, in_edge.edge_weight, in_edge.last_edge,
                  tag);
    end
  end

  // Result beats against the oldest expectation
  always @(posedge clk) begin : result_check
    res_t got;
    res_t want;
    if (rst_n && out_res.valid && out_res.ready) begin
      got.vertex_index    = out_res.vertex_index;
      got.reachable       = out_res.reachable;
      got.distance        = out_res.distance;
      got.predecessor     = out_res.predecessor;
      got.has_predecessor = out_res.has_predecessor;
      got.negative_cycle  = out_res.negative_cycle;
      got.last_result     = out_res.last_result;
      result_beats++;
      if (due_results.size() == 0) begin
        err_count++;
        $display("%0t: result beat for vertex %0d with nothing expected", $time,
                 got.vertex_index);
      end else begin
        want = due_results.pop_front();
        check_field("vertex_index", want.vertex_index, got.vertex_index);
        check_field("reachable", want.reachable, got.reachable);
        check_field("distance", want.distance, got.distance);
        check_field("predecessor", want.predecessor, got.predecessor);
        check_field("has_predecessor", want.has_predecessor, got.has_predecessor);
        check_field("negative_cycle", want.negative_cycle, got.negative_cycle);
        check_field("last_result", want.last_result, got.last_result);
      end
    end
  end

  // Result-side backpressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_res.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_res.ready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  task automatic send_edge(vtx_t f, vtx_t t, weight_t w, bit last, int tag);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_edge.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    known_tag.insert(known_tag.size(), tag);
    in_edge.valid       <= 1'b1;
    in_edge.edge_from   <= f;
    in_edge.edge_to     <= t;
    in_edge.edge_weight <= w;
    in_edge.last_edge   <= last;
    do @(posedge clk); while (!in_edge.ready);
  endtask

  // Hold off edges until every expected result is out and the block has settled;
  // the first edge lets the monitor take in the last accepted edge beat
  task automatic drain();
    in_edge.valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apb_write(logic [ADDR_BITS-1:0] addr, logic [DATA_BITS-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr[2] == REG_VCOUNT) vc_reg = data[CNT_BITS-1:0];
    else src_reg = data[VTX_BITS-1:0];
    cfg_writes++;
  endtask

  task automatic apb_read(logic [ADDR_BITS-1:0] addr, output logic [DATA_BITS-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
  endtask

  // Write both registers while idle and read them back
  task automatic configure(int vc, int src);
    logic [DATA_BITS-1:0] back;
    drain();
    apb_write(VCOUNT_ADDR, DATA_BITS'(vc));
    apb_write(SOURCE_ADDR, DATA_BITS'(src));
    apb_read(VCOUNT_ADDR, back);
    check_field("vertex_count readback", vcount_t'(vc), back[CNT_BITS-1:0]);
    apb_read(SOURCE_ADDR, back);
    check_field("source_vertex readback", vtx_t'(src), back[VTX_BITS-1:0]);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin : stimulus
    int   vc;
    int   nv;
    int   n;
    int   rand_edges;
    bit   first;
    vtx_t tail;
    vtx_t f;
    vtx_t t;

    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    in_edge.valid       <= 1'b0;
    in_edge.edge_from   <= '0;
    in_edge.edge_to     <= '0;
    in_edge.edge_weight <= '0;
    in_edge.last_edge   <= 1'b0;
    rst_n               <= 1'b0;
    calm = 1'b0;

    // Directed plan: reset defaults, weight extremes, negative cycle, source outside
    // the graph, dropped edges, empty graph, count saturation both ways, a mid-graph
    // shrink of the vertex count, and a negative cycle the source cannot reach.
    add_known(0, 1, 0, 0, 0, 0, 0);
    add_known(1, 1, 32767, 0, 1, 0, 1);
    add_row(0, 0, 0, 0, 1, 32767, 1, 2);
    add_known(0, 1, 0, 0, 0, 0, 0);
    add_known(1, 0, 0, 0, 0, 0, 1);
    add_row(0, 0, 0, 1, 0, -32768, 1, 2);
    add_row(0, 0, 0, 0, 1, -1, 0, 0);
    add_known(0, 0, 0, 0, 0, 1, 1);
    add_row(0, 0, 0, 1, 0, 0, 1, 1);
    add_known(0, 0, 0, 0, 0, 0, 0);
    add_known(1, 0, 0, 0, 0, 0, 1);
    add_row(1, 2, 5, 0, 1, 1, 1, 2);
    add_row(1, 2, 0, 0, 63, 7, 0, 0);
    add_known(0, 1, 0, 0, 0, 0, 0);
    add_known(1, 0, 0, 0, 0, 0, 1);
    add_row(0, 0, 0, 63, 0, 7, 1, 2);
    add_known(0, 1, -5, 1, 1, 0, 0);
    add_known(1, 1, 0, 0, 0, 0, 1);
    add_row(1, 1, 1, 1, 0, -5, 1, 2);
    add_row(1, 0, 0, 0, 1, 3, 0, 0);
    add_row(0, 0, 0, 0, 1, 2, 1, 0);
    add_row(1, 127, 63, 63, 62, 100, 0, 0);
    add_row(0, 0, 0, 62, 0, -100, 0, 0);
    add_row(0, 0, 0, 0, 63, 50, 1, 0);
    add_row(1, 64, 0, 0, 1, 32767, 0, 0);
    add_row(0, 0, 0, 1, 2, 32767, 0, 0);
    add_row(0, 0, 0, 2, 63, -32768, 1, 0);
    add_row(1, 8, 0, 0, 7, 4, 0, 0);
    add_row(0, 0, 0, 7, 1, -2, 0, 0);
    add_row(1, 4, 0, 0, 2, 9, 1, 0);
    add_row(1, 5, 0, 2, 3, -10, 0, 0);
    add_row(0, 0, 0, 3, 2, 1, 0, 0);
    add_row(0, 0, 0, 0, 1, 6, 1, 0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].reconfig) configure(plan[i].vcount, plan[i].source);
      send_edge(plan[i].tail, plan[i].head, plan[i].weight, plan[i].last,
                plan[i].known_count > 0 ? i : -1);
    end

    // Random graphs: path-like edge chains from the source with some stray edges
    rand_edges = 0;
    first = 1'b1;
    while (rand_edges < RANDOM_EDGES) begin
      calm = ($urandom_range(0, 3) == 0);
      if (first || $urandom_range(0, 9) < 4) begin
        n = $urandom_range(0, 99);
        if (n < 65) vc = $urandom_range(2, 12);
        else if (n < 80) vc = $urandom_range(13, 64);
        else if (n < 90) vc = 64;
        else vc = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(65, 127);
        configure(vc, $urandom_range(0, 6) == 0 ? $urandom_range(0, 63)
                                                : $urandom_range(0, sat_count(vc) - 1));
        first = 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        drain();
      end
      nv = sat_count(vc_reg);
      n = $urandom_range(0, 10);
      tail = src_reg;
      for (int k = 0; k <= n; k++) begin
        f = ($urandom_range(0, 9) < 6) ? tail : pick_vertex(nv);
        t = pick_vertex(nv);
        tail = t;
        if (f < nv && t < nv) rand_edges++;
        send_edge(f, t, pick_weight(), k == n, -1);
      end
    end

    calm = 1'b0;
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d graphs from %0d edge beats (%0d with a negative cycle).",
             graphs, edge_beats, neg_graphs);
    $display("Checked %0d result beats; %0d register writes with readback.",
             result_beats, cfg_writes);
    if (err_count == 0 && due_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("Timeout with %0d results outstanding", due_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
